/* rtl/i2cs_pkg.sv */
// Shared types, codes and constants of the I2C register-map slave.
package i2cs_pkg;

  // Default number of map entries
  localparam int MAP_DEPTH_DEFAULT = 256;

  // Modulo dividend: pointer plus a 16-bit byte count
  localparam int DIV_W = 17;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Configuration reset values
  localparam logic [6:0] OWN_ADDR_RESET   = 7'h12;
  localparam logic [8:0] MAP_SIZE_RESET   = 9'd256;
  localparam logic [1:0] ADDR_BYTES_RESET = 2'd1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_OWN_ADDR   = 2'd0,
    CFG_MAP_SIZE   = 2'd1,
    CFG_ADDR_BYTES = 2'd2
  } cfg_idx_e;

  // Event opcodes
  typedef enum logic [2:0] {
    OP_START     = 3'd0,
    OP_STOP      = 3'd1,
    OP_MWRITE    = 3'd2,
    OP_MREAD     = 3'd3,
    OP_HWRITE    = 3'd4,
    OP_HREAD     = 3'd5,
    OP_CLR_START = 3'd6,
    OP_CLR_STOP  = 3'd7
  } opcode_e;

  typedef struct packed {
    logic [6:0] own_address;
    logic [8:0] map_size;
    logic [1:0] address_bytes;
  } cfg_t;

  // Classified event handed from front to back
  typedef struct packed {
    opcode_e    op;
    logic       matched;
    logic [7:0] data;
    logic [7:0] host_index;
  } cmd_t;

  // Modulo unit request and status
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
  } mod_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_status_t;

  // Result item, first field in the highest bits
  typedef struct packed {
    logic [6:0]  pad;
    logic [15:0] register_pointer;
    logic [15:0] read_count;
    logic [15:0] written_count;
    logic [15:0] stop_count;
    logic [15:0] start_count;
    logic        address_matched;
    logic [7:0]  read_data;
  } result_t;

endpackage

/* rtl/i2c_slave_register_map.sv */
// Top level of the I2C register-map slave: configuration and front/back pairing.
//
// Each bus or host event enters through the input stream, is classified and
// queued (two entries) by the front end, and is executed by the back end, which
// returns one result per event on the output stream. Start, stop, clear and
// pointer-building writes are executed as they are taken from the queue and
// need no map access. Host map reads and writes and master map reads and
// writes reduce each map index, and for master accesses first the pointer,
// modulo the map size by a shared bit-serial remainder unit of 17 steps plus a
// done strobe. The map is a single-port memory with a registered read. After
// reset the map is cleared entry by entry, during which no event is
// accepted; configuration writes are taken at all times.
module i2c_slave_register_map import i2cs_pkg::*; #(
  parameter int MapDepth = MAP_DEPTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // bus_address[6:0], data_byte[14:7],
                                     // host_index[22:15], zero[23]
  input  logic [2:0]  s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata   // read_data[7:0], address_matched[8],
                                     // start_count[24:9], stop_count[40:25],
                                     // written_count[56:41], read_count[72:57],
                                     // register_pointer[88:73], zero[95:89]
);

  cfg_t cfg_q, cfg_d;
  logic q_valid, q_pop, init_done;
  cmd_t q_cmd;

  // Write configuration registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_OWN_ADDR:   cfg_d.own_address   = cfg_data_i[6:0];
        CFG_MAP_SIZE:   cfg_d.map_size      = cfg_data_i;
        CFG_ADDR_BYTES: cfg_d.address_bytes = cfg_data_i[1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_address   <= OWN_ADDR_RESET;
      cfg_q.map_size      <= MAP_SIZE_RESET;
      cfg_q.address_bytes <= ADDR_BYTES_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  i2cs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .enable_i     (init_done),
    .own_address_i(cfg_q.own_address),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .q_valid_o    (q_valid),
    .q_cmd_o      (q_cmd),
    .q_pop_i      (q_pop)
  );

  i2cs_back #(
    .MapDepth(MapDepth)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_valid_i    (q_valid),
    .q_cmd_i      (q_cmd),
    .q_pop_o      (q_pop),
    .init_done_o  (init_done),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule

/* rtl/i2cs_front.sv */
// Front end: accepts events, classifies them and queues them for the back end.
module i2cs_front import i2cs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        enable_i,
  input  logic [6:0]  own_address_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // bus_address, data_byte, host_index, pad
  input  logic [2:0]  s_axis_tuser,  // opcode
  output logic        q_valid_o,
  output cmd_t        q_cmd_o,
  input  logic        q_pop_i
);

  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);

  cmd_t             q_mem [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]   cnt_q, cnt_d;
  logic             push, pop;
  cmd_t             cmd_in;
  opcode_e          op_in;

  // Classify the incoming event
  always_comb begin
    op_in              = opcode_e'(s_axis_tuser);
    cmd_in.op          = op_in;
    cmd_in.matched     = ((op_in == OP_START) || (op_in == OP_STOP)) &&
                         (s_axis_tdata[6:0] == own_address_i);
    cmd_in.data        = s_axis_tdata[14:7];
    cmd_in.host_index  = s_axis_tdata[22:15];
  end

  assign s_axis_tready = enable_i && (cnt_q != (QPtrW+1)'(QDepth));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = q_pop_i && (cnt_q != '0);
  assign q_valid_o     = (cnt_q != '0);
  assign q_cmd_o       = q_mem[rd_ptr_q];

  // Advance queue pointers and fill count
  always_comb begin
    wr_ptr_d = push ? QPtrW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop  ? QPtrW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store queued events
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

/* rtl/i2cs_modulo.sv */
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module i2cs_modulo import i2cs_pkg::*; #(
  parameter int SizeW = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mod_req_t         req_i,
  input  logic [SizeW-1:0] divisor_i,
  output mod_status_t      st_o,
  output logic [SizeW-1:0] rem_o
);

  logic                 busy_q, busy_d, done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     div_q, div_d;
  logic [SizeW-1:0]     rem_q, rem_d;
  logic [SizeW:0]       trial;
  logic                 ge;

  // Shift in the next dividend bit and subtract when it fits
  assign trial = {rem_q, div_q[DIV_W-1]};
  assign ge    = (trial >= {1'b0, divisor_i});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (busy_q) begin
      rem_d = ge ? SizeW'(trial - {1'b0, divisor_i}) : trial[SizeW-1:0];
      div_d = {div_q[DIV_W-2:0], 1'b0};
      cnt_d = DIV_CNT_W'(cnt_q + 1'b1);
      if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      div_d  = req_i.dividend;
      rem_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign st_o.busy = busy_q;
  assign st_o.done = done_q;
  assign rem_o     = rem_q;

endmodule

/* rtl/i2cs_back.sv */
// Back end: executes queued events on counters, pointer and register map.
module i2cs_back import i2cs_pkg::*; #(
  parameter int MapDepth = MAP_DEPTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        q_valid_i,
  input  cmd_t        q_cmd_i,
  output logic        q_pop_o,
  output logic        init_done_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata
);

  localparam int AW = (MapDepth > 1) ? $clog2(MapDepth) : 1;
  localparam int SW = $clog2(MapDepth + 1);

  typedef enum logic [6:0] {
    ST_INIT = 7'b0000001,
    ST_IDLE = 7'b0000010,
    ST_RED  = 7'b0000100,
    ST_IDX  = 7'b0001000,
    ST_LOAD = 7'b0010000,
    ST_OUT  = 7'b0100000,
    ST_SPARE = 7'b1000000
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] init_cnt_q, init_cnt_d;
  logic [15:0]   ptr_q, ptr_d, starts_q, starts_d, stops_q, stops_d;
  logic [15:0]   bw_q, bw_d, br_q, br_d;
  logic [15:0]   ptr_base;
  cmd_t          cmd_q, cmd_d;
  result_t       out_q, out_d;
  logic          out_load;

  logic [7:0]    map_mem [MapDepth];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata, rd_q;

  logic [SW-1:0] eff_size;
  mod_req_t      mod_req;
  mod_status_t   mod_st;
  logic [SW-1:0] mod_rem;

  // Saturate the configured map size to 1..MapDepth
  always_comb begin
    if (cfg_i.map_size == '0) begin
      eff_size = SW'(1);
    end else if (32'(cfg_i.map_size) > MapDepth) begin
      eff_size = SW'(MapDepth);
    end else begin
      eff_size = SW'(cfg_i.map_size);
    end
  end

  i2cs_modulo #(
    .SizeW(SW)
  ) u_modulo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mod_req),
    .divisor_i(eff_size),
    .st_o     (mod_st),
    .rem_o    (mod_rem)
  );

  assign ptr_base = (bw_q == '0) ? '0 : ptr_q;

  // Sequence one event at a time
  always_comb begin
    state_d    = state_q;
    init_cnt_d = init_cnt_q;
    ptr_d      = ptr_q;
    starts_d   = starts_q;
    stops_d    = stops_q;
    bw_d       = bw_q;
    br_d       = br_q;
    cmd_d      = cmd_q;
    q_pop_o    = 1'b0;
    mod_req    = '0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = init_cnt_q;
    mem_wdata  = '0;
    out_load   = 1'b0;
    out_d      = out_q;

    unique case (state_q)
      // Clear the map entry by entry after reset
      ST_INIT: begin
        mem_we     = 1'b1;
        init_cnt_d = AW'(init_cnt_q + 1'b1);
        if (init_cnt_q == AW'(MapDepth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      // Take the next event and do the ones that need no reduction at once
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          unique case (q_cmd_i.op)
            OP_START: begin
              if (q_cmd_i.matched) starts_d = starts_q + 16'd1;
              state_d = ST_LOAD;
            end
            OP_STOP: begin
              if (q_cmd_i.matched) begin
                stops_d = stops_q + 16'd1;
                bw_d    = '0;
                br_d    = '0;
              end
              state_d = ST_LOAD;
            end
            OP_MWRITE: begin
              if (bw_q < 16'(cfg_i.address_bytes)) begin
                ptr_d   = {ptr_base[7:0], q_cmd_i.data};
                bw_d    = bw_q + 16'd1;
                state_d = ST_LOAD;
              end else begin
                ptr_d            = ptr_base;
                mod_req.start    = 1'b1;
                mod_req.dividend = DIV_W'(ptr_base);
                state_d          = ST_RED;
              end
            end
            OP_MREAD: begin
              mod_req.start    = 1'b1;
              mod_req.dividend = DIV_W'(ptr_q);
              state_d          = ST_RED;
            end
            OP_HWRITE, OP_HREAD: begin
              mod_req.start    = 1'b1;
              mod_req.dividend = DIV_W'(q_cmd_i.host_index);
              state_d          = ST_IDX;
            end
            OP_CLR_START: begin
              starts_d = '0;
              state_d  = ST_LOAD;
            end
            OP_CLR_STOP: begin
              stops_d = '0;
              state_d = ST_LOAD;
            end
            default: state_d = ST_LOAD;
          endcase
        end
      end
      // Reduce the pointer, then start the map index
      ST_RED: begin
        if (mod_st.done) begin
          ptr_d         = 16'(mod_rem);
          mod_req.start = 1'b1;
          if (cmd_q.op == OP_MWRITE) begin
            mod_req.dividend = DIV_W'(mod_rem) + DIV_W'(bw_q) -
                               DIV_W'(cfg_i.address_bytes);
          end else begin
            mod_req.dividend = DIV_W'(mod_rem) + DIV_W'(br_q);
          end
          state_d = ST_IDX;
        end
      end
      // Access the map at the wrapped index
      ST_IDX: begin
        if (mod_st.done) begin
          mem_addr = mod_rem[AW-1:0];
          if ((cmd_q.op == OP_MWRITE) || (cmd_q.op == OP_HWRITE)) begin
            mem_we    = 1'b1;
            mem_wdata = cmd_q.data;
          end else begin
            mem_re = 1'b1;
          end
          if (cmd_q.op == OP_MWRITE) bw_d = bw_q + 16'd1;
          if (cmd_q.op == OP_MREAD)  br_d = br_q + 16'd1;
          state_d = ST_LOAD;
        end
      end
      // Capture the result
      ST_LOAD: begin
        out_load                = 1'b1;
        out_d.pad               = '0;
        out_d.register_pointer  = ptr_q;
        out_d.read_count        = br_q;
        out_d.written_count     = bw_q;
        out_d.stop_count        = stops_q;
        out_d.start_count       = starts_q;
        out_d.address_matched   = cmd_q.matched;
        out_d.read_data         = ((cmd_q.op == OP_MREAD) || (cmd_q.op == OP_HREAD)) ?
                                  rd_q : 8'h00;
        state_d                 = ST_OUT;
      end
      // Hold the result until taken
      ST_OUT: begin
        if (m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      init_cnt_q <= '0;
      ptr_q      <= '0;
      starts_q   <= '0;
      stops_q    <= '0;
      bw_q       <= '0;
      br_q       <= '0;
    end else begin
      state_q    <= state_d;
      init_cnt_q <= init_cnt_d;
      ptr_q      <= ptr_d;
      starts_q   <= starts_d;
      stops_q    <= stops_d;
      bw_q       <= bw_d;
      br_q       <= br_d;
    end
  end

  // Event and result payload
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (out_load) out_q <= out_d;
  end

  // Register map: one write or one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) map_mem[mem_addr] <= mem_wdata;
    if (mem_re) rd_q <= map_mem[mem_addr];
  end

  assign init_done_o   = (state_q != ST_INIT);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = out_q;

endmodule

/* rtl/i2cs_checker.sv */
// Port-level checker for the I2C register-map slave, bound to the top level.
module i2cs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Drop valid in the cycle after each result transaction
  a_out_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
    else $error("result repeated without a new event");

  // Hold off events at the start of the map clear after reset
  a_init_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !s_axis_tready)
    else $error("event accepted during map clear");

  // A matched start or stop returns no map data and a zero pad
  a_match_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[8] |-> (m_axis_tdata[7:0] == 8'h00) &&
    (m_axis_tdata[95:89] == 7'h00))
    else $error("matched event carries read data");

endmodule

bind i2c_slave_register_map i2cs_checker u_i2cs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
